// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Implication and next-cycle forms, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/pgc_pkg.sv =====
// ----------------------------------------------------------------------------
// pgc_pkg - prime gap champion shared definitions
// Request/response payloads and controller/datapath command and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgc_pkg;

  localparam int NUM_LIMIT_DEF = 65536;
  localparam int MAX_GAP_DEF   = 128;
  localparam int HIST_W        = 16;
  localparam int GAP_OUT_W     = 7;

  typedef struct packed {
    logic [15:0] range_low;
    logic [15:0] range_high;
  } req_t;

  typedef struct packed {
    logic                 has_champion;
    logic [GAP_OUT_W-1:0] champion_gap;
  } rsp_t;

  typedef struct packed {
    logic fill;        // bitmap fill sweep
    logic sieve_init;  // start sieve at 2
    logic sieve_rd;    // read bitmap at sieve index
    logic mark_init;   // load strike pointer with i*i
    logic mark;        // strike one multiple
    logic sieve_next;  // advance sieve index
    logic accept;      // take a request
    logic clear;       // histogram clear sweep
    logic walk;        // range walk
    logic hist_wr;     // histogram increment write
    logic scan;        // histogram max scan
    logic load_res;    // load response register
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic map_prime;
    logic sieve_last;
    logic mark_last;
    logic empty;
    logic clr_last;
    logic walk_hit;
    logic walk_end;
    logic scan_end;
    logic res_busy;
  } sts_t;

endpackage

// ===== sv/pgc_dp.sv =====
// ----------------------------------------------------------------------------
// pgc_dp - prime gap champion datapath
// Prime bitmap and gap histogram memories, walk and scan pointers, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgc_dp #(
  parameter int NUM_LIMIT = pgc_pkg::NUM_LIMIT_DEF,
  parameter int MAX_GAP   = pgc_pkg::MAX_GAP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pgc_pkg::cmd_t  cmd,
  output pgc_pkg::sts_t  sts,
  input  pgc_pkg::req_t  req,
  output pgc_pkg::rsp_t  rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);

  localparam int AW = $clog2(NUM_LIMIT);
  localparam int JW = AW + 1;
  localparam int GW = $clog2(MAX_GAP);
  localparam int HW = pgc_pkg::HIST_W;

  // memories
  logic          map_mem [NUM_LIMIT];
  logic          map_rd;
  logic [AW-1:0] map_raddr;
  logic [AW-1:0] map_waddr;
  logic          map_we;
  logic          map_wdata;

  logic [HW-1:0] hist_mem [MAX_GAP];
  logic [HW-1:0] hist_rd;
  logic [GW-1:0] hist_raddr;
  logic [GW-1:0] hist_waddr;
  logic          hist_we;
  logic [HW-1:0] hist_wdata;

  // control flags and pointers
  logic [AW-1:0] n;
  logic          issue_done;
  logic          pend;
  logic          have_prev;
  logic          counted;
  logic          scan_done;
  logic          spend;

  // payload registers
  logic [AW-1:0] pend_n;
  logic [AW-1:0] prev;
  logic [GW-1:0] gap;
  logic [AW-1:0] hi;
  logic          empty;
  logic [AW-1:0] i;
  logic [JW-1:0] sq;
  logic [JW-1:0] j;
  logic [GW-1:0] c;
  logic [GW-1:0] spend_c;
  logic [HW-1:0] best;
  logic [GW-1:0] best_gap;
  logic          uniq;

  // combinational
  logic [AW-1:0] gap_c;
  logic          gap_ok;
  logic          walk_hit;
  logic [JW-1:0] sq_next;
  logic [JW-1:0] j_next;
  logic [AW-1:0] hi_c;
  logic          empty_c;
  logic          champ;

  assign gap_c    = pend_n - prev;
  assign gap_ok   = 32'(gap_c) < MAX_GAP;
  assign walk_hit = cmd.walk & pend & map_rd & have_prev & gap_ok;
  assign sq_next  = sq + {i, 1'b1};
  assign j_next   = j + JW'(i);
  assign hi_c     = (32'(req.range_high) > 32'(NUM_LIMIT - 1)) ? AW'(NUM_LIMIT - 1)
                                                               : AW'(req.range_high);
  assign empty_c  = 32'(req.range_low) > 32'(hi_c);
  assign champ    = counted & uniq;

  assign sts.fill_last  = 32'(n) == 32'(NUM_LIMIT - 1);
  assign sts.map_prime  = map_rd;
  assign sts.sieve_last = 32'(sq_next) >= 32'(NUM_LIMIT);
  assign sts.mark_last  = 32'(j_next) >= 32'(NUM_LIMIT);
  assign sts.empty      = empty;
  assign sts.clr_last   = 32'(c) == 32'(MAX_GAP - 1);
  assign sts.walk_hit   = walk_hit;
  assign sts.walk_end   = issue_done & ~pend;
  assign sts.scan_end   = scan_done & ~spend;
  assign sts.res_busy   = rsp_valid & rsp_stall;

  // bitmap port muxing
  assign map_raddr = cmd.sieve_rd ? i : n;
  assign map_we    = cmd.fill | cmd.mark;
  assign map_waddr = cmd.fill ? n : j[AW-1:0];
  assign map_wdata = cmd.fill & (n >= AW'(2));

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd <= map_mem[map_raddr];
  end

  // histogram port muxing, saturating increment
  assign hist_raddr = cmd.scan ? c : gap;
  assign hist_we    = cmd.clear | cmd.hist_wr;
  assign hist_waddr = cmd.clear ? c : gap;
  assign hist_wdata = cmd.clear ? '0 : ((hist_rd == '1) ? hist_rd : hist_rd + 1'b1);

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd <= hist_mem[hist_raddr];
  end

  // control flags and walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      n          <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      have_prev  <= 1'b0;
      counted    <= 1'b0;
      scan_done  <= 1'b0;
      spend      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.fill) begin
        n <= n + 1'b1;
      end
      if (cmd.accept) begin
        n          <= AW'(req.range_low);
        issue_done <= 1'b0;
        pend       <= 1'b0;
        have_prev  <= 1'b0;
        counted    <= 1'b0;
      end
      if (cmd.walk) begin
        if (pend & map_rd) begin
          have_prev <= 1'b1;
        end
        if (walk_hit) begin
          // drop the read in flight, resume after the histogram update
          counted    <= 1'b1;
          pend       <= 1'b0;
          n          <= pend_n + 1'b1;
          issue_done <= (pend_n == hi);
        end else if (!issue_done) begin
          pend       <= 1'b1;
          n          <= n + 1'b1;
          issue_done <= (n == hi);
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.clear) begin
        scan_done <= 1'b0;
        spend     <= 1'b0;
      end
      if (cmd.scan) begin
        if (!scan_done) begin
          spend     <= 1'b1;
          scan_done <= sts.clr_last;
        end else begin
          spend <= 1'b0;
        end
      end
      if (cmd.load_res) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.sieve_init) begin
      i  <= AW'(2);
      sq <= JW'(4);
    end
    if (cmd.sieve_next) begin
      i  <= i + 1'b1;
      sq <= sq_next;
    end
    if (cmd.mark_init) begin
      j <= sq;
    end
    if (cmd.mark) begin
      j <= j_next;
    end
    if (cmd.accept) begin
      hi    <= hi_c;
      empty <= empty_c;
      c     <= '0;
    end
    if (cmd.walk) begin
      if (!walk_hit && !issue_done) begin
        pend_n <= n;
      end
      if (pend & map_rd) begin
        prev <= pend_n;
      end
      if (walk_hit) begin
        gap <= GW'(gap_c);
      end
    end
    if (cmd.clear) begin
      c    <= sts.clr_last ? '0 : c + 1'b1;
      best <= '0;
      uniq <= 1'b0;
    end
    if (cmd.scan) begin
      if (!scan_done) begin
        c       <= c + 1'b1;
        spend_c <= c;
      end
      if (spend) begin
        if (hist_rd > best) begin
          best     <= hist_rd;
          best_gap <= spend_c;
          uniq     <= 1'b1;
        end else if (hist_rd == best) begin
          uniq <= 1'b0;
        end
      end
    end
    if (cmd.load_res) begin
      rsp.has_champion <= champ;
      rsp.champion_gap <= champ ? pgc_pkg::GAP_OUT_W'(best_gap) : '0;
    end
  end

endmodule

// ===== sv/pgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pgc_ctrl - prime gap champion controller
// Sequences bitmap build, then per request: clear, walk, scan, respond (empty ranges skip walk and scan).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output pgc_pkg::cmd_t  cmd,
  input  pgc_pkg::sts_t  sts
);

  typedef enum logic [3:0] {
    S_FILL,
    S_SRD,
    S_SCHK,
    S_MARK,
    S_IDLE,
    S_CLR,
    S_WALK,
    S_HRD,
    S_HWR,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          cmd.sieve_init = 1'b1;
          state_next     = S_SRD;
        end
      end
      S_SRD: begin
        cmd.sieve_rd = 1'b1;
        state_next   = S_SCHK;
      end
      S_SCHK: begin
        if (sts.map_prime) begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK;
        end else begin
          cmd.sieve_next = 1'b1;
          state_next     = sts.sieve_last ? S_IDLE : S_SRD;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          cmd.sieve_next = 1'b1;
          state_next     = sts.sieve_last ? S_IDLE : S_SRD;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = sts.empty ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_hit) begin
          state_next = S_HRD;
        end else if (sts.walk_end) begin
          state_next = S_SCAN;
        end
      end
      S_HRD: begin
        state_next = S_HWR;
      end
      S_HWR: begin
        cmd.hist_wr = 1'b1;
        state_next  = S_WALK;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.res_busy) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/prime_gap_champion.sv =====
// Per request: histogram clear, walk of the range (one number per cycle, paused for the
//   read-modify-write of each counted gap), scan, respond; empty ranges skip walk and scan.
// Throughput: one request at a time; the next is taken once the response is loaded.
// Reset: all NUM_LIMIT bitmap bits filled, then the sieve strikes the multiples of each
//   prime p below sqrt(NUM_LIMIT) from p*p up, one write a cycle; no request is taken until it ends.
// ----------------------------------------------------------------------------
// prime_gap_champion - jumping champion of prime gaps over a range
// Sieve-built prime bitmap, gap histogram per request, unique-mode answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prime_gap_champion #(
  parameter int NUM_LIMIT = pgc_pkg::NUM_LIMIT_DEF,
  parameter int MAX_GAP   = pgc_pkg::MAX_GAP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // request: range_low..range_high
  input  logic           req_valid,
  output logic           req_stall,
  input  pgc_pkg::req_t  req,
  // response: has_champion, champion_gap
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pgc_pkg::rsp_t  rsp
);

  // Controller and datapath talk only through these two groups.
  pgc_pkg::cmd_t cmd;
  pgc_pkg::sts_t sts;

  // Controller: build sequence after reset, then clear/walk/scan/respond
  // for each request. req_stall is low only while waiting for a request.
  pgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: the bitmap is one bit per number with a registered read;
  // the walk issues one read a cycle and pauses for a histogram read-modify-write for
  // each gap that lands in the histogram. The scan keeps the running maximum and
  // whether it is unique, so a tie leaves no champion. The response sits
  // in its own register, so a new request can start while it waits.
  pgc_dp #(
    .NUM_LIMIT (NUM_LIMIT),
    .MAX_GAP   (MAX_GAP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // A taken request holds off the next one.
  `ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)
  // The response register is never overwritten while it is stalled.
  `ASSERT_IMPLY(a_no_rsp_overwrite, clk, rst, cmd.load_res, !(rsp_valid && rsp_stall))
  // No champion means a zero gap.
  `ASSERT_IMPLY(a_zero_gap, clk, rst, rsp_valid && !rsp.has_champion, rsp.champion_gap == '0)
  // A counted gap leaves the walk for the histogram read cycle.
  `ASSERT_NEXT(a_hit_then_read, clk, rst, sts.walk_hit, !cmd.walk && !cmd.hist_wr)

endmodule

// ===== tb/tb_prime_gap_champion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_gap_champion - range query checker for the prime gap champion
// Drives range requests and predicts each answer from the testbench's own
// sieve and gap histogram. Every response is compared field by field, in order.
// ----------------------------------------------------------------------------

module tb_prime_gap_champion;

  localparam int NUM_LIMIT   = pgc_pkg::NUM_LIMIT_DEF;
  localparam int MAX_GAP     = pgc_pkg::MAX_GAP_DEF;
  // Reset alone is a full bitmap fill plus the strike pass; the
  // three wide directed requests walk ~100k numbers; the random ones are short.
  localparam int CYCLE_LIMIT = 4000000;
  // Tail wait once drained: covers a clear sweep and a scan of the histogram.
  localparam int TAIL_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side
  logic          req_valid = 1'b0;
  logic          req_stall;
  pgc_pkg::req_t req       = '0;
  // response side
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  pgc_pkg::rsp_t rsp;

  prime_gap_champion uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  bit            is_prime [NUM_LIMIT];   // testbench copy of the prime bitmap
  pgc_pkg::req_t range_queue[$];         // requests not yet driven
  pgc_pkg::rsp_t champion_expected[$];   // predicted answers, oldest first
  pgc_pkg::rsp_t want;

  logic req_taken = 1'b0;       // request accepted at the last rising edge
  int   cycle_count   = 0;
  int   query_count   = 0;
  int   answer_count  = 0;
  int   champion_seen = 0;
  int   error_count   = 0;

  // A window of requests with both sides running flat out.
  wire steady = (query_count >= 40) && (query_count < 70);

  // --------------------------------------------------------------------------
  // Predictor: clamp, walk the primes of the range, histogram the gaps, then
  // answer only when exactly one gap holds the top count.
  // --------------------------------------------------------------------------
  function automatic pgc_pkg::rsp_t champion_of(input pgc_pkg::req_t r);
    int unsigned   lo, hi, n, prev, g, best, best_gap, ties;
    bit            have_prev, counted;
    int unsigned   gap_count [MAX_GAP];
    pgc_pkg::rsp_t res;
    lo        = r.range_low;
    hi        = r.range_high;
    prev      = 0;
    best      = 0;
    best_gap  = 0;
    ties      = 0;
    have_prev = 1'b0;
    counted   = 1'b0;
    foreach (gap_count[i]) gap_count[i] = 0;
    if (hi > NUM_LIMIT - 1) hi = NUM_LIMIT - 1;
    // low above high: the loop does not run, nothing counted, no champion
    for (n = lo; n <= hi; n++) begin
      if (is_prime[n]) begin
        if (have_prev) begin
          g = n - prev;
          // gaps of MAX_GAP or more are dropped
          if (g < MAX_GAP) begin
            if (gap_count[g] != 16'hFFFF) gap_count[g]++;  // saturating count
            counted = 1'b1;
          end
        end
        prev      = n;
        have_prev = 1'b1;
      end
    end
    res = '0;
    if (counted) begin
      for (g = 0; g < MAX_GAP; g++) begin
        if (gap_count[g] > best) begin
          best     = gap_count[g];
          best_gap = g;
        end
      end
      for (g = 0; g < MAX_GAP; g++) begin
        if (gap_count[g] == best) ties++;
      end
      if (ties == 1) begin
        res.has_champion = 1'b1;
        res.champion_gap = best_gap[pgc_pkg::GAP_OUT_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH at answer %0d: %s got %0d, expected %0d",
             answer_count, what, got, exp_val);
    error_count++;
  endtask

  task automatic push_range(input int unsigned lo, input int unsigned hi);
    pgc_pkg::req_t r;
    r.range_low  = lo[15:0];
    r.range_high = hi[15:0];
    range_queue.push_back(r);
  endtask

  // Random ranges: mostly short windows anywhere in the 16-bit space, some
  // tiny ones (no primes, ties), a few wide ones, and some with low above high.
  task automatic queue_random_ranges(input int count);
    int unsigned lo, hi, width, kind;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(99);
      lo   = $urandom_range(65535);
      if (kind < 6) begin
        hi = (lo == 0) ? 0 : $urandom_range(lo - 1);
      end else begin
        if (kind < 16)      width = $urandom_range(4096);
        else if (kind < 32) width = $urandom_range(40);
        else                width = $urandom_range(600);
        hi = (lo + width > 65535) ? 65535 : lo + width;
      end
      push_range(lo, hi);
    end
  endtask

  // Idle until nothing is queued, in flight or owed by the block.
  task automatic wait_drained();
    while (range_queue.size() != 0 || req_valid || champion_expected.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs move on the falling edge. A held request keeps its payload
  // until the edge that takes it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (range_queue.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
          req       <= range_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= !steady && ($urandom_range(99) < 32);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples on the rising edge. Accepted requests are predicted right
  // away; accepted responses are checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    req_taken   <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      champion_expected.push_back(champion_of(req));
      query_count++;
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (champion_expected.size() == 0) begin
        report_mismatch("response with no request outstanding, has_champion",
                        rsp.has_champion, 0);
      end else begin
        want = champion_expected.pop_front();
        if (rsp.has_champion !== want.has_champion)
          report_mismatch("has_champion", rsp.has_champion, want.has_champion);
        if (rsp.champion_gap !== want.champion_gap)
          report_mismatch("champion_gap", rsp.champion_gap, want.champion_gap);
        if (want.has_champion) champion_seen++;
      end
      answer_count++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers still owed",
               cycle_count, champion_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: sieve, reset, directed ranges, then two random batches with a
  // full drain in between each phase.
  // --------------------------------------------------------------------------
  initial begin
    foreach (is_prime[i]) is_prime[i] = (i >= 2);
    for (int i = 2; i * i < NUM_LIMIT; i++) begin
      if (is_prime[i]) begin
        for (int j = i * i; j < NUM_LIMIT; j += i) is_prime[j] = 1'b0;
      end
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    push_range(0, 0);            // no primes at all
    push_range(0, 2);            // a single prime
    push_range(24, 28);          // composite run
    push_range(2, 3);            // one gap of 1
    push_range(2, 5);            // gaps 1 and 2 tie
    push_range(2, 7);            // gap 2 wins
    push_range(31397, 31469);    // lone gap of 72, the widest below the limit
    push_range(0, 65535);        // whole map
    push_range(32768, 65535);    // top half, top bit of low set
    push_range(65000, 65535);    // high at the top of the field
    push_range(65535, 65535);
    push_range(65535, 0);        // low above high, both extremes
    push_range(1, 0);
    push_range(16'hAAAA, 16'h5555);
    push_range(16'h5555, 16'h5A55);
    push_range(100, 200);
    push_range(1000, 1100);
    push_range(89, 97);          // single gap of 8
    wait_drained();

    queue_random_ranges(41);
    wait_drained();
    queue_random_ranges(41);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d range requests in %0d cycles: %0d with a champion, %0d without",
             answer_count, cycle_count, champion_seen, answer_count - champion_seen);
    $display("Directed edges covered empty, tied, inverted and full-map ranges");
    if (error_count == 0 && champion_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d answers missing", error_count, champion_expected.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== prime_gap_champion.f =====
+incdir+sv
sv/pgc_pkg.sv
sv/pgc_dp.sv
sv/pgc_ctrl.sv
sv/prime_gap_champion.sv
tb/tb_prime_gap_champion.sv
